// ===== hdl/irpd_pkg.sv =====
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants for the IR pulse-distance transmitter.
// ----------------------------------------------------------------------------
package irpd_pkg;

    // Word length of a frame; bits WORD_BITS-1 down to 1 are sent
    localparam int WORD_BITS = 16;
    localparam int DATA_W    = 16;
    localparam int KEY_W     = $clog2(WORD_BITS);

    // Frame: six bursts with five sync gaps, then gap+burst per sent bit
    localparam int SEG_COUNT = 11 + 2 * (WORD_BITS - 1);
    localparam int SEG_W     = $clog2(SEG_COUNT);
    localparam int SIDX_W    = SEG_W + 1;
    localparam int SYNC_N    = 5;

    localparam logic [11:0] SYNC_GAPS [SYNC_N] = '{12'd2500, 12'd995, 12'd995,
                                                   12'd995, 12'd1945};

    // Queues between the three parts
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_TICKS   = 3'd0,
        REG_CTOP    = 3'd1,
        REG_CCMP    = 3'd2,
        REG_GAP_ADJ = 3'd3,
        REG_BURST   = 3'd4,
        REG_ONE_GAP = 3'd5,
        REG_ZERO_GAP = 3'd6
    } reg_idx_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef struct packed {
        logic [4:0]  ticks_per_us;
        logic [5:0]  carrier_top;
        logic [5:0]  carrier_compare;
        logic [9:0]  gap_adjust;
        logic [9:0]  burst_length;
        logic [11:0] one_gap;
        logic [11:0] zero_gap;
    } cfg_t;

    typedef struct packed {
        op_t              op;
        logic [DATA_W-1:0] word;
    } item_t;

    typedef struct packed {
        logic ir_out;
        logic busy;
        logic accepted;
        logic done;
    } res_t;

endpackage

// ===== hdl/irpd_cfg.sv =====
// ----------------------------------------------------------------------------
// irpd_cfg
// APB register file holding the timing and carrier settings.
// ----------------------------------------------------------------------------
module irpd_cfg
    import irpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [2:0] reg_idx;
    logic       wr_en;
    cfg_t       cfg_reg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_us    <= 5'd16;
            cfg_reg.carrier_top     <= 6'd35;
            cfg_reg.carrier_compare <= 6'd17;
            cfg_reg.gap_adjust      <= 10'd0;
            cfg_reg.burst_length    <= 10'd50;
            cfg_reg.one_gap         <= 12'd1500;
            cfg_reg.zero_gap        <= 12'd1000;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TICKS:    cfg_reg.ticks_per_us    <= pwdata[4:0];
                REG_CTOP:     cfg_reg.carrier_top     <= pwdata[5:0];
                REG_CCMP:     cfg_reg.carrier_compare <= pwdata[5:0];
                REG_GAP_ADJ:  cfg_reg.gap_adjust      <= pwdata[9:0];
                REG_BURST:    cfg_reg.burst_length    <= pwdata[9:0];
                REG_ONE_GAP:  cfg_reg.one_gap         <= pwdata[11:0];
                REG_ZERO_GAP: cfg_reg.zero_gap        <= pwdata[11:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TICKS:    prdata = PDATA_W'(cfg_reg.ticks_per_us);
            REG_CTOP:     prdata = PDATA_W'(cfg_reg.carrier_top);
            REG_CCMP:     prdata = PDATA_W'(cfg_reg.carrier_compare);
            REG_GAP_ADJ:  prdata = PDATA_W'(cfg_reg.gap_adjust);
            REG_BURST:    prdata = PDATA_W'(cfg_reg.burst_length);
            REG_ONE_GAP:  prdata = PDATA_W'(cfg_reg.one_gap);
            REG_ZERO_GAP: prdata = PDATA_W'(cfg_reg.zero_gap);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== hdl/irpd_front.sv =====
// ----------------------------------------------------------------------------
// irpd_front
// Takes requests, classifies them as tick or start and queues them.
// ----------------------------------------------------------------------------
module irpd_front
    import irpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              operation,
    input  logic [DATA_W-1:0] data_word,
    output item_t             head,
    output logic              head_valid,
    input  logic              take
);

    item_t           q_mem [Q_DEPTH];
    logic [Q_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;
    item_t           new_item;

    assign full       = (count_reg == Q_CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = q_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = take && head_valid;

    always_comb
    begin
        new_item.op   = op_t'(operation);
        new_item.word = data_word;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + Q_CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - Q_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= new_item;
    end

endmodule

// ===== hdl/irpd_back.sv =====
// ----------------------------------------------------------------------------
// irpd_back
// Frame sequencer: carrier, microsecond timer, segment walk, result queue.
// ----------------------------------------------------------------------------
module irpd_back
    import irpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  item_t head,
    input  logic  head_valid,
    output logic  take,
    output res_t  res_head,
    output logic  res_empty,
    input  logic  res_pop
);

    // Sequencer state
    logic [5:0]           carrier_reg, carrier_next;
    logic [4:0]           prescale_reg, prescale_next;
    logic [11:0]          remaining_reg, remaining_next;
    logic [SEG_W-1:0]     seg_reg, seg_next;
    logic [WORD_BITS-1:0] bit_shift_reg, bit_shift_next;
    logic                 burst_reg, burst_next;
    logic                 sending_reg, sending_next;

    // Result queue
    res_t            r_mem [Q_DEPTH];
    logic [Q_PW-1:0] r_wr_reg, r_wr_next;
    logic [Q_PW-1:0] r_rd_reg, r_rd_next;
    logic [Q_CW-1:0] r_count_reg, r_count_next;
    logic            r_pop;

    logic                 exec;
    logic                 is_start;
    logic                 enter;
    logic                 accepted;
    logic                 done;
    logic [WORD_BITS-1:0] word_sel;
    logic [SIDX_W-1:0]    search_start;
    logic                 found;
    logic [SEG_W-1:0]     found_idx;
    logic [11:0]          found_len;
    logic                 nz_j;
    logic                 one_nz;
    logic                 zero_nz;
    logic                 burst_nz;
    logic [SYNC_N-1:0]    sync_nz;
    logic [11:0]          adj;
    res_t                 res_new;

    function automatic logic [11:0] seg_len(input logic [SEG_W-1:0]     idx,
                                            input logic [WORD_BITS-1:0] word,
                                            input cfg_t                 c);
        logic [11:0] gap;
        int          k;
        k = WORD_BITS - 1 - ((int'(idx) - 11) >>> 1);
        if (!idx[0])
            return 12'(c.burst_length);
        if (idx < SEG_W'(10))
            gap = SYNC_GAPS[idx[3:1]];
        else
            gap = word[k[KEY_W-1:0]] ? c.one_gap : c.zero_gap;
        return (gap > 12'(c.gap_adjust)) ? gap - 12'(c.gap_adjust) : 12'd0;
    endfunction

    assign r_pop     = res_pop && !res_empty;
    assign res_empty = (r_count_reg == '0);
    assign res_head  = r_mem[r_rd_reg];
    assign exec      = head_valid && ((r_count_reg != Q_CW'(Q_DEPTH)) || r_pop);
    assign take      = exec;
    assign is_start  = (head.op == OP_START);
    assign adj       = 12'(cfg.gap_adjust);

    // Which segment classes have nonzero length under the current settings
    always_comb
    begin
        one_nz   = cfg.one_gap > adj;
        zero_nz  = cfg.zero_gap > adj;
        burst_nz = (cfg.burst_length != '0);
        for (int s = 0; s < SYNC_N; s++)
            sync_nz[s] = SYNC_GAPS[s] > adj;
    end

    // First nonzero segment at or after search_start
    always_comb
    begin
        word_sel     = is_start ? WORD_BITS'(head.word) : bit_shift_reg;
        search_start = is_start ? '0 : SIDX_W'(seg_reg) + SIDX_W'(1);
        found        = 1'b0;
        found_idx    = '0;
        nz_j         = 1'b0;
        for (int j = SEG_COUNT - 1; j >= 0; j--)
        begin
            if ((j & 1) == 0)
                nz_j = burst_nz;
            else if (j < 10)
                nz_j = sync_nz[j >> 1];
            else
                nz_j = word_sel[WORD_BITS - 1 - ((j - 11) >> 1)] ? one_nz : zero_nz;
            if (nz_j && (SIDX_W'(j) >= search_start))
            begin
                found     = 1'b1;
                found_idx = SEG_W'(j);
            end
        end
        found_len = seg_len(found_idx, word_sel, cfg);
    end

    always_comb
    begin
        carrier_next   = carrier_reg;
        prescale_next  = prescale_reg;
        remaining_next = remaining_reg;
        seg_next       = seg_reg;
        bit_shift_next = bit_shift_reg;
        burst_next     = burst_reg;
        sending_next   = sending_reg;
        enter          = 1'b0;
        accepted       = 1'b0;
        done           = 1'b0;

        if (is_start)
        begin
            // start while a frame is running is dropped
            if (!sending_reg)
            begin
                bit_shift_next = WORD_BITS'(head.word);
                sending_next   = 1'b1;
                accepted       = 1'b1;
                enter          = 1'b1;
            end
        end
        else
        begin
            carrier_next = (carrier_reg >= cfg.carrier_top) ? '0 : carrier_reg + 6'd1;
            if (sending_reg)
            begin
                // rate of zero behaves as one
                if ({1'b0, prescale_reg} + 6'd1 >= {1'b0, cfg.ticks_per_us})
                begin
                    prescale_next = '0;
                    if (remaining_reg <= 12'd1)
                        enter = 1'b1;
                    else
                        remaining_next = remaining_reg - 12'd1;
                end
                else
                begin
                    prescale_next = prescale_reg + 5'd1;
                end
            end
        end

        if (enter)
        begin
            prescale_next = '0;
            if (found)
            begin
                seg_next       = found_idx;
                remaining_next = found_len;
                burst_next     = !found_idx[0];
            end
            else
            begin
                seg_next       = '0;
                remaining_next = '0;
                burst_next     = 1'b0;
                sending_next   = 1'b0;
                done           = 1'b1;
            end
        end

        res_new.ir_out   = burst_next && sending_next && (carrier_next <= cfg.carrier_compare);
        res_new.busy     = sending_next;
        res_new.accepted = accepted;
        res_new.done     = done;
    end

    always_comb
    begin
        r_wr_next    = r_wr_reg;
        r_rd_next    = r_rd_reg;
        r_count_next = r_count_reg;
        if (exec)
            r_wr_next = (r_wr_reg == Q_PW'(Q_DEPTH - 1)) ? '0 : r_wr_reg + Q_PW'(1);
        if (r_pop)
            r_rd_next = (r_rd_reg == Q_PW'(Q_DEPTH - 1)) ? '0 : r_rd_reg + Q_PW'(1);
        if (exec && !r_pop)
            r_count_next = r_count_reg + Q_CW'(1);
        else if (r_pop && !exec)
            r_count_next = r_count_reg - Q_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_reg   <= '0;
            prescale_reg  <= '0;
            remaining_reg <= '0;
            seg_reg       <= '0;
            bit_shift_reg <= '0;
            burst_reg     <= 1'b0;
            sending_reg   <= 1'b0;
            r_wr_reg      <= '0;
            r_rd_reg      <= '0;
            r_count_reg   <= '0;
        end
        else
        begin
            if (exec)
            begin
                carrier_reg   <= carrier_next;
                prescale_reg  <= prescale_next;
                remaining_reg <= remaining_next;
                seg_reg       <= seg_next;
                bit_shift_reg <= bit_shift_next;
                burst_reg     <= burst_next;
                sending_reg   <= sending_next;
            end
            r_wr_reg    <= r_wr_next;
            r_rd_reg    <= r_rd_next;
            r_count_reg <= r_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
            r_mem[r_wr_reg] <= res_new;
    end

endmodule

// ===== hdl/ir_pulse_distance_transmitter.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter
// IR pulse-distance frame transmitter with queue-style request/result ports.
// ----------------------------------------------------------------------------
// Each request is a timer tick or a start; each gives exactly one result
// (LED level, busy, start taken, frame done). One request per clock is
// sustained unless the result queue is full and not popped. A result can be
// popped once its request has passed through the two-entry request queue and
// the two-entry result queue. Either side may stall without stopping the
// other until its queue fills. The user must write settings over the APB port
// only while no request is in flight; the block itself does not enforce this.
module ir_pulse_distance_transmitter
    import irpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               operation,
    input  logic [DATA_W-1:0]  data_word,
    output logic               empty,
    input  logic               pop,
    output logic               ir_out,
    output logic               busy_res,
    output logic               start_accepted,
    output logic               frame_done,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t  cfg;
    item_t head;
    logic  head_valid;
    logic  take;
    res_t  res_head;

    irpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    irpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .data_word  (data_word),
        .head       (head),
        .head_valid (head_valid),
        .take       (take)
    );

    irpd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head       (head),
        .head_valid (head_valid),
        .take       (take),
        .res_head   (res_head),
        .res_empty  (empty),
        .res_pop    (pop)
    );

    assign ir_out         = res_head.ir_out;
    assign busy_res       = res_head.busy;
    assign start_accepted = res_head.accepted;
    assign frame_done     = res_head.done;

endmodule

// ===== tb/tb_ir_pulse_distance_transmitter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_pulse_distance_transmitter
// Self-checking bench for the IR pulse-distance transmitter. A short stimulus
// table is followed by random phases. Each phase programs the settings over
// APB and reads them back. Every result is checked against a frame predictor
// in the bench or, for typed rows, the table's own expectation. Both queue
// sides stall at random; once, the result side holds off till the block fills.
// ----------------------------------------------------------------------------
module tb_ir_pulse_distance_transmitter;
    import irpd_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYC  = 8;
    localparam int RX_HOLD     = 300;
    localparam int HOLD_ITEMS  = 30;
    localparam int MAX_REPORTS = 40;
    localparam int DIR_ROWS    = 8;
    localparam int N_PHASES    = 6;

    typedef struct {
        op_t         op;
        logic [15:0] word;
        int          reps;
        bit          typed;
        res_t        want;
    } dir_row_t;

    typedef struct {
        cfg_t cfg;
        int   items;
        int   start_pm;   // chance of a start request, per mille
    } phase_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               operation = 1'b0;
    logic [DATA_W-1:0]  data_word = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic               ir_out;
    logic               busy_res;
    logic               start_accepted;
    logic               frame_done;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // typed expectation travelling alongside the request
    logic               want_typed = 1'b0;
    res_t               want_res = '0;

    int  errors = 0;
    int  reg_errors = 0;
    int  cycles = 0;
    bit  hold_ask = 1'b0;
    bit  hold_taken = 1'b0;
    bit  rx_holding = 1'b0;

    res_t pending_results [$];

    // frame predictor state
    cfg_t        settings = '{5'd16, 6'd35, 6'd17, 10'd0, 10'd50, 12'd1500, 12'd1000};
    logic [5:0]  carr_cnt = '0;
    logic [4:0]  tick_pre = '0;
    logic [11:0] us_left = '0;
    int          seg_idx = 0;
    logic [15:0] word_sr = '0;
    logic        in_burst = 1'b0;
    logic        frame_on = 1'b0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{OP_TICK,  16'h0000, 1,  1'b1, 4'b0000},
        '{OP_TICK,  16'hFFFF, 1,  1'b1, 4'b0000},
        '{OP_START, 16'hFFFF, 1,  1'b1, 4'b1110},
        '{OP_START, 16'h0000, 1,  1'b1, 4'b1100},   // busy, so ignored
        '{OP_TICK,  16'h1234, 16, 1'b0, 4'b0000},   // carrier passes compare
        '{OP_START, 16'h5555, 1,  1'b0, 4'b0000},
        '{OP_START, 16'hAAAA, 1,  1'b0, 4'b0000},
        '{OP_TICK,  16'h0000, 3,  1'b0, 4'b0000}
    };

    // zero gap/burst skipping, tick rate zero and carrier extremes are spread over
    // these
    phase_t phase_plan [N_PHASES] = '{
        '{'{5'd1,  6'd35, 6'd17, 10'd1023, 10'd1,    12'd1030, 12'd0},    150, 3},
        '{'{5'd0,  6'd63, 6'd0,  10'd900,  10'd0,    12'd950,  12'd901},  140, 3},
        '{'{5'd1,  6'd0,  6'd63, 10'd1023, 10'd3,    12'd0,    12'd1030}, 120, 3},
        '{'{5'd31, 6'd1,  6'd1,  10'd0,    10'd1023, 12'd4095, 12'd4095}, 90,  20},
        '{'{5'd16, 6'd35, 6'd17, 10'd0,    10'd50,   12'd1500, 12'd1000}, 80,  10},
        '{'{5'd5,  6'd10, 6'd4,  10'd512,  10'd200,  12'd600,  12'd2000}, 90,  10}
    };

    ir_pulse_distance_transmitter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .data_word      (data_word),
        .empty          (empty),
        .pop            (pop),
        .ir_out         (ir_out),
        .busy_res       (busy_res),
        .start_accepted (start_accepted),
        .frame_done     (frame_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("ir_pulse_distance_transmitter regression: fail");
            $finish;
        end
    end

    // Enter the first segment from 'first' on with a nonzero length; 0 when the
    // frame has run out of segments.
    function automatic bit enter_segment(int first);
        int unsigned len;
        int unsigned gap;
        for (int i = first; i < SEG_COUNT; i++)
        begin
            if (i % 2 == 0)
                len = settings.burst_length;
            else
            begin
                if (i < 10)
                    gap = SYNC_GAPS[i / 2];
                else if (word_sr[WORD_BITS - 1 - (i - 11) / 2])
                    gap = settings.one_gap;
                else
                    gap = settings.zero_gap;
                len = (gap > settings.gap_adjust) ? gap - settings.gap_adjust : 0;
            end
            if (len != 0)
            begin
                seg_idx  = i;
                us_left  = 12'(len);
                in_burst = (i % 2 == 0);
                tick_pre = '0;
                return 1'b1;
            end
        end
        seg_idx  = 0;
        us_left  = '0;
        in_burst = 1'b0;
        frame_on = 1'b0;
        tick_pre = '0;
        return 1'b0;
    endfunction

    function automatic res_t next_led_result(op_t op, logic [15:0] word);
        res_t r;
        r = '0;
        if (op == OP_START)
        begin
            if (!frame_on)
            begin
                word_sr    = word;
                frame_on   = 1'b1;
                r.accepted = 1'b1;
                if (!enter_segment(0))
                    r.done = 1'b1;
            end
        end
        else
        begin
            // carrier runs free, idle or not
            carr_cnt = (carr_cnt >= settings.carrier_top) ? '0 : carr_cnt + 6'd1;
            if (frame_on)
            begin
                if (int'(tick_pre) + 1 >= int'(settings.ticks_per_us))
                begin
                    tick_pre = '0;
                    if (us_left <= 12'd1)
                    begin
                        if (!enter_segment(seg_idx + 1))
                            r.done = 1'b1;
                    end
                    else
                        us_left = us_left - 12'd1;
                end
                else
                    tick_pre = tick_pre + 5'd1;
            end
        end
        r.ir_out = in_burst && frame_on && (carr_cnt <= settings.carrier_compare);
        r.busy   = frame_on;
        return r;
    endfunction

    function automatic logic [31:0] cfg_field(cfg_t c, reg_idx_t idx);
        case (idx)
            REG_TICKS:   return 32'(c.ticks_per_us);
            REG_CTOP:    return 32'(c.carrier_top);
            REG_CCMP:    return 32'(c.carrier_compare);
            REG_GAP_ADJ: return 32'(c.gap_adjust);
            REG_BURST:   return 32'(c.burst_length);
            REG_ONE_GAP: return 32'(c.one_gap);
            default:     return 32'(c.zero_gap);
        endcase
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic cmp_field(string what, logic want, logic got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s expected %0b, got %0b", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        res_t predicted;
        res_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                predicted = next_led_result(op_t'(operation), data_word);
                pending_results.push_back(want_typed ? want_res : predicted);
            end
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t ns: expected no result, got ir %0b busy %0b acc %0b done %0b",
                                 $time, ir_out, busy_res, start_accepted, frame_done);
                end
                else
                begin
                    want = pending_results.pop_front();
                    cmp_field("ir_out", want.ir_out, ir_out);
                    cmp_field("busy_res", want.busy, busy_res);
                    cmp_field("start_accepted", want.accepted, start_accepted);
                    cmp_field("frame_done", want.done, frame_done);
                end
            end
        end
    end

    // result side: random stalls, and one long hold-off on request
    initial
    begin : result_side
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_ask && !hold_taken)
            begin
                hold_taken = 1'b1;
                rx_holding = 1'b1;
                pop <= 1'b0;
                repeat (RX_HOLD) @(posedge clk);
                rx_holding = 1'b0;
                stall = 0;
            end
            else
                stall = pick_gap();
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge clk);
        end
    end

    // Leaves push high; the caller lowers it when a gap follows.
    task automatic send_item(op_t op, logic [15:0] word, logic typed, res_t want);
        push       <= 1'b1;
        operation  <= op;
        data_word  <= word;
        want_typed <= typed;
        want_res   <= want;
        do @(posedge clk); while (full);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // write, then read back in the next transfer
    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        if (rd !== val)
        begin
            reg_errors++;
            $display("%0t ns: register %s expected %0d, got %0d", $time, idx.name(), val, rd);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : request_side
        int   gap;
        op_t  op;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[r])
        begin
            for (int n = 0; n < dir_tab[r].reps; n++)
                send_item(dir_tab[r].op, dir_tab[r].word, dir_tab[r].typed, dir_tab[r].want);
        end
        wait_drained();

        for (int p = 0; p < N_PHASES; p++)
        begin
            for (int k = 0; k <= int'(REG_ZERO_GAP); k++)
                reg_write(reg_idx_t'(k), cfg_field(phase_plan[p].cfg, reg_idx_t'(k)));
            settings = phase_plan[p].cfg;

            // first phase: result side stops while requests pile up
            if (p == 0)
            begin
                hold_ask = 1'b1;
                wait (rx_holding);
            end

            for (int i = 0; i < phase_plan[p].items; i++)
            begin
                if (i == phase_plan[p].items / 2)
                    wait_drained();
                if ((p == 0 && i < HOLD_ITEMS) || (i % 200 < 40))
                    gap = 0;
                else
                    gap = pick_gap();
                if (gap > 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                if (i == 0 || $urandom_range(999) < phase_plan[p].start_pm)
                    op = OP_START;
                else
                    op = OP_TICK;
                send_item(op, 16'($urandom), 1'b0, '0);
            end
            wait_drained();
        end

        if (errors == 0 && reg_errors == 0)
            $display("ir_pulse_distance_transmitter regression: pass");
        else
            $display("ir_pulse_distance_transmitter regression: fail");
        $finish;
    end

endmodule
